### rtl/hrsp_pkg.sv
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types and codes for the HTTP request stream parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    // parser phases
    localparam logic [2:0] PH_REQ  = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_BODY = 3'd2;
    localparam logic [2:0] PH_DONE = 3'd3;
    localparam logic [2:0] PH_ERR  = 3'd4;

    // byte classes
    localparam logic [2:0] CLS_METHOD = 3'd0;
    localparam logic [2:0] CLS_TARGET = 3'd1;
    localparam logic [2:0] CLS_VER    = 3'd2;
    localparam logic [2:0] CLS_NAME   = 3'd3;
    localparam logic [2:0] CLS_VALUE  = 3'd4;
    localparam logic [2:0] CLS_DELIM  = 3'd5;
    localparam logic [2:0] CLS_BODY   = 3'd6;
    localparam logic [2:0] CLS_IGN    = 3'd7;

    // parse status codes
    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    // connection verdicts
    localparam logic [1:0] CONN_NONE  = 2'd0;
    localparam logic [1:0] CONN_CLOSE = 2'd1;
    localparam logic [1:0] CONN_KEEP  = 2'd2;

    // parser state apart from the length counters
    typedef struct packed {
        logic [2:0] phase;
        logic       pending_cr;
        logic [1:0] line_field;
        logic [1:0] field_nonempty;
        logic [3:0] vpos;
        logic       v11;
        logic       seen_colon;
        logic [4:0] nm0;
        logic [4:0] nm1;
        logic       hf0;
        logic       hf1;
        logic [1:0] lsign;
        logic [3:0] wm0;
        logic [3:0] wm1;
        logic [1:0] conn;
    } t_pstate;

    // one result item
    typedef struct packed {
        logic [31:0] body_length;
        logic        keep_alive;
        logic        headers_done;
        logic [1:0]  parse_status;
        logic        prev_cr_was_data;
        logic [2:0]  byte_class;
        logic [7:0]  byte_out;
    } t_result;

    localparam t_pstate PSTATE_RST = '{
        phase: PH_REQ, conn: CONN_NONE, default: '0
    };

endpackage

### rtl/hrsp_step.sv
// ----------------------------------------------------------------------------
// hrsp_step
// Next-state and result logic for one byte of the request stream.
// ----------------------------------------------------------------------------
module hrsp_step #(
    parameter int LB = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  hrsp_pkg::t_pstate i_st,
    input  logic [LB-1:0]     i_len,
    input  logic [LB-1:0]     i_rem,
    input  logic              i_restart,
    input  logic [7:0]        i_c,
    output hrsp_pkg::t_pstate o_st,
    output logic [LB-1:0]     o_len,
    output logic [LB-1:0]     o_rem,
    output hrsp_pkg::t_result o_res
);
    import hrsp_pkg::*;

    localparam logic [4:0] NM_FAIL = 5'd31;
    localparam logic [3:0] VM_FAIL = 4'd15;
    localparam logic [4:0] NLEN0 = 5'd14;
    localparam logic [4:0] NLEN1 = 5'd10;
    localparam logic [3:0] WLEN0 = 4'd5;
    localparam logic [3:0] WLEN1 = 4'd10;
    localparam logic [8*14-1:0] NAME0 = "content-length";
    localparam logic [8*10-1:0] NAME1 = "connection";
    localparam logic [8*5-1:0]  WORD0 = "close";
    localparam logic [8*10-1:0] WORD1 = "keep-alive";
    localparam logic [8*7-1:0]  VPFX  = "HTTP/1.";
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_COLON = 8'd58;
    localparam logic [7:0] CH_PLUS = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_0 = 8'd48;
    localparam logic [7:0] CH_1 = 8'd49;
    localparam logic [LB-1:0] LEN_MAX = '1;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] low_case(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    // one step of a header name matcher, n = name length
    function automatic logic [4:0] step_name(input logic [4:0] m, input logic [4:0] n,
                                             input logic [7:0] ch, input logic [7:0] c);
        logic [4:0] r;
        r = m;
        if (m != NM_FAIL) begin
            if (is_ws(c)) begin
                if (m != 5'd0 && m != n) r = NM_FAIL;
            end else if (m < n && low_case(c) == ch) begin
                r = m + 5'd1;
            end else begin
                r = NM_FAIL;
            end
        end
        return r;
    endfunction

    // one step of a connection word matcher
    function automatic logic [3:0] step_word(input logic [3:0] m, input logic [3:0] n,
                                             input logic [7:0] ch, input logic [7:0] first,
                                             input logic [7:0] lc);
        logic [3:0] r;
        r = m;
        if (m < n) begin
            if (lc == ch) r = m + 4'd1;
            else r = (lc == first) ? 4'd1 : 4'd0;
        end
        return r;
    endfunction

    // apply one content byte to the current line, returns its class
    function automatic logic [2:0] content(inout t_pstate s, inout logic [LB-1:0] len,
                                           input logic [7:0] c);
        logic [2:0]    cls;
        logic [7:0]    lc;
        logic          dig;
        logic          acc;
        logic [LB+3:0] wide;
        cls = CLS_VER;
        lc = low_case(c);
        dig = (c >= CH_0) && (c <= CH_0 + 8'd9);
        acc = 1'b0;
        if (s.phase == PH_REQ) begin
            if (s.line_field == 2'd0) begin
                if (c == CH_SP) begin
                    s.line_field = 2'd1;
                    cls = CLS_DELIM;
                end else begin
                    s.field_nonempty[0] = 1'b1;
                    cls = CLS_METHOD;
                end
            end else if (s.line_field == 2'd1) begin
                if (c == CH_SP) begin
                    s.line_field = 2'd2;
                    cls = CLS_DELIM;
                end else begin
                    s.field_nonempty[1] = 1'b1;
                    cls = CLS_TARGET;
                end
            end else begin
                // version string match
                if (s.vpos < 4'd7) begin
                    s.vpos = (c == VPFX[8*(6-int'(s.vpos)) +: 8]) ? s.vpos + 4'd1 : VM_FAIL;
                end else if (s.vpos == 4'd7) begin
                    if (c == CH_1) begin
                        s.v11 = 1'b1;
                        s.vpos = 4'd8;
                    end else if (c == CH_0) begin
                        s.v11 = 1'b0;
                        s.vpos = 4'd8;
                    end else begin
                        s.vpos = VM_FAIL;
                    end
                end else begin
                    s.vpos = VM_FAIL;
                end
                cls = CLS_VER;
            end
        end else begin
            s.field_nonempty[0] = 1'b1;
            if (!s.seen_colon) begin
                if (c == CH_COLON) begin
                    s.seen_colon = 1'b1;
                    if (s.nm0 == NLEN0 && !s.hf0) s.hf0 = 1'b1;
                    else s.nm0 = NM_FAIL;
                    if (s.nm1 == NLEN1 && !s.hf1) s.hf1 = 1'b1;
                    else s.nm1 = NM_FAIL;
                    cls = CLS_DELIM;
                end else begin
                    if (!is_ws(c)) s.field_nonempty[1] = 1'b1;
                    s.nm0 = step_name(s.nm0, NLEN0,
                        (s.nm0 < NLEN0) ? NAME0[8*(13-int'(s.nm0)) +: 8] : 8'd0, c);
                    s.nm1 = step_name(s.nm1, NLEN1,
                        (s.nm1 < NLEN1) ? NAME1[8*(9-int'(s.nm1)) +: 8] : 8'd0, c);
                    cls = CLS_NAME;
                end
            end else begin
                // content-length value: sign then digits
                if (s.nm0 == NLEN0) begin
                    unique case (s.lsign)
                        2'd0: begin
                            if (!is_ws(c)) begin
                                if (c == CH_PLUS) s.lsign = 2'd1;
                                else if (c == CH_MINUS) s.lsign = 2'd2;
                                else if (!dig) s.lsign = 2'd3;
                                else begin
                                    s.lsign = 2'd1;
                                    acc = 1'b1;
                                end
                            end
                        end
                        2'd1: begin
                            if (!dig) s.lsign = 2'd3;
                            else acc = 1'b1;
                        end
                        2'd2: begin
                            if (!dig) s.lsign = 2'd3;
                        end
                        default: ;
                    endcase
                    if (acc) begin
                        wide = ({4'd0, len} << 3) + ({4'd0, len} << 1)
                             + (LB+4)'(c - CH_0);
                        len = (wide[LB+3:LB] != 4'd0) ? LEN_MAX : wide[LB-1:0];
                    end
                end
                // connection value word search
                if (s.nm1 == NLEN1) begin
                    s.wm0 = step_word(s.wm0, WLEN0,
                        (s.wm0 < WLEN0) ? WORD0[8*(4-int'(s.wm0)) +: 8] : 8'd0,
                        WORD0[39:32], lc);
                    s.wm1 = step_word(s.wm1, WLEN1,
                        (s.wm1 < WLEN1) ? WORD1[8*(9-int'(s.wm1)) +: 8] : 8'd0,
                        WORD1[79:72], lc);
                end
                cls = CLS_VALUE;
            end
        end
        return cls;
    endfunction

    // per-byte update
    always_comb begin
        t_pstate       s;
        logic [LB-1:0] len;
        logic [LB-1:0] rem;
        logic [2:0]    cls;
        logic          crd;
        logic          hdone;
        logic          after;
        s = i_st;
        len = i_len;
        rem = i_rem;
        cls = CLS_IGN;
        crd = 1'b0;
        hdone = 1'b0;
        after = 1'b0;
        o_res = '0;
        o_res.byte_out = i_c;
        o_res.byte_class = CLS_IGN;
        if (i_restart) begin
            s = PSTATE_RST;
            len = '0;
            rem = '0;
        end else begin
            if (s.phase == PH_REQ || s.phase == PH_HDR) begin
                // held CR not followed by LF becomes content
                if (s.pending_cr && i_c != CH_LF) begin
                    void'(content(s, len, CH_CR));
                    crd = 1'b1;
                    s.pending_cr = 1'b0;
                end
                if (s.pending_cr) begin
                    // line end
                    s.pending_cr = 1'b0;
                    cls = CLS_DELIM;
                    if (s.phase == PH_REQ) begin
                        if (s.line_field == 2'd2 && s.field_nonempty == 2'd3 && s.vpos == 4'd8)
                            s.phase = PH_HDR;
                        else
                            s.phase = PH_ERR;
                    end else if (!s.seen_colon && !s.field_nonempty[0]) begin
                        if (s.hf1 && s.wm0 >= WLEN0) s.conn = CONN_CLOSE;
                        else if (s.hf1 && s.wm1 >= WLEN1) s.conn = CONN_KEEP;
                        else s.conn = s.v11 ? CONN_KEEP : CONN_CLOSE;
                        rem = len;
                        s.phase = (len == '0) ? PH_DONE : PH_BODY;
                        hdone = 1'b1;
                    end else if (!s.seen_colon || !s.field_nonempty[1]) begin
                        s.phase = PH_ERR;
                    end
                    s.line_field = 2'd0;
                    s.field_nonempty = 2'd0;
                    s.seen_colon = 1'b0;
                    s.nm0 = 5'd0;
                    s.nm1 = 5'd0;
                end else if (i_c == CH_CR) begin
                    s.pending_cr = 1'b1;
                    cls = CLS_DELIM;
                end else begin
                    cls = content(s, len, i_c);
                end
            end else if (s.phase == PH_BODY) begin
                cls = CLS_BODY;
                if (rem != '0) rem = rem - LB'(1);
                if (rem == '0) s.phase = PH_DONE;
            end
            after = (s.phase == PH_BODY) || (s.phase == PH_DONE);
            o_res.byte_class = cls;
            o_res.prev_cr_was_data = crd;
            o_res.headers_done = hdone;
            if (s.phase == PH_ERR) o_res.parse_status = ST_ERR;
            else if (s.phase == PH_DONE) o_res.parse_status = ST_DONE;
            else o_res.parse_status = ST_MORE;
            o_res.keep_alive = after && (s.conn == CONN_KEEP);
            o_res.body_length = after ? 32'({32'd0, len}) : 32'd0;
        end
        o_st = s;
        o_len = len;
        o_rem = rem;
    end

endmodule

### rtl/http_request_stream_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_stream_parser_core
// Byte-at-a-time HTTP/1.x request parser with a registered result stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one transfer per request byte. tdata carries the byte,
//   tuser set means restart the parser for a new request (the byte is
//   passed through and tagged ignored, all state returns to reset).
//   Output channel: one transfer per input transfer, in order, carrying the
//   byte, its field class in tuser and the parse status, header-end flag,
//   keep-alive verdict and body length in tdata.
//   Output valid rises in the cycle after the input transfer. Throughput is
//   one byte per clock unless the receiver stalls; each byte is parsed in
//   a single pass of the step logic between state and result registers.
//   Reset (synchronous, active low) puts the parser at the start of a
//   request line and empties the result register.
//   When the receiver stalls, the result register holds its item and input
//   ready drops until the item is taken; a new byte is accepted in the same
//   cycle the held result leaves.
// ----------------------------------------------------------------------------
module http_request_stream_parser_core #(
    parameter int LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] byte_out, [8] prev_cr_was_data, [10:9] parse_status,
    // [11] headers_done, [12] keep_alive, [44:13] body_length, [47:45] zero
    output logic [47:0] o_m_axis_tdata,
    output logic [2:0]  o_m_axis_tuser    // [2:0] byte_class
);
    import hrsp_pkg::*;

    t_pstate              r_st, n_st;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    t_result              r_res, n_res;
    logic                 r_valid;
    logic                 w_acc;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign w_acc = i_s_axis_tvalid && o_s_axis_tready;

    // single-pass byte step
    hrsp_step #(.LB(LENGTH_BITS)) u_step (
        .i_st      (r_st),
        .i_len     (r_len),
        .i_rem     (r_rem),
        .i_restart (i_s_axis_tuser),
        .i_c       (i_s_axis_tdata),
        .o_st      (n_st),
        .o_len     (n_len),
        .o_rem     (n_rem),
        .o_res     (n_res)
    );

    // parser state, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= PSTATE_RST;
            r_len <= '0;
            r_rem <= '0;
        end else if (w_acc) begin
            r_st <= n_st;
            r_len <= n_len;
            r_rem <= n_rem;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_res.byte_class;
    assign o_m_axis_tdata  = {3'd0, r_res.body_length, r_res.keep_alive, r_res.headers_done,
                              r_res.parse_status, r_res.prev_cr_was_data, r_res.byte_out};

endmodule

### dv/http_request_stream_parser_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_request_stream_parser_core_checker
// Watches both channels of the parser, runs its own byte-level parse of the
// accepted request stream and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module http_request_stream_parser_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [47:0] i_m_tdata,
    input  logic [2:0]  i_m_tuser,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_status_seen [3]
);
    import hrsp_pkg::*;

    // parser copy
    logic [2:0]  ph;
    logic        cr_held;
    logic [1:0]  lfield;
    logic [1:0]  nonempty;
    logic [3:0]  vpos;
    logic        v11;
    logic        colon;
    logic [4:0]  nmat [2];
    logic        found [2];
    logic [63:0] len_acc;
    logic [1:0]  lsign;
    logic [3:0]  wmat [2];
    logic [1:0]  verdict;
    logic [31:0] remain;

    t_result parsed_q [$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = parsed_q.size();

    function automatic bit is_space(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] fold(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] name_char(int i, int k);
        string s;
        s = (i == 0) ? "content-length" : "connection";
        return s[k];
    endfunction

    function automatic logic [7:0] word_char(int i, int k);
        string s;
        s = (i == 0) ? "close" : "keep-alive";
        return s[k];
    endfunction

    function automatic void parser_clear();
        ph = PH_REQ; cr_held = 0; lfield = 0; nonempty = 0; vpos = 0; v11 = 0;
        colon = 0; nmat[0] = 0; nmat[1] = 0; found[0] = 0; found[1] = 0;
        len_acc = 0; lsign = 0; wmat[0] = 0; wmat[1] = 0; verdict = CONN_NONE;
        remain = 0;
    endfunction

    function automatic void line_clear();
        lfield = 0; nonempty = 0; colon = 0; nmat[0] = 0; nmat[1] = 0;
    endfunction

    // one content byte of the current line; returns its class
    function automatic logic [2:0] take_content(logic [7:0] c);
        int nlen;
        int wl;
        int m;
        string pre;
        pre = "HTTP/1.";
        if (ph == PH_REQ) begin
            if (lfield == 0) begin
                if (c == 8'd32) begin lfield = 1; return CLS_DELIM; end
                nonempty[0] = 1; return CLS_METHOD;
            end
            if (lfield == 1) begin
                if (c == 8'd32) begin lfield = 2; return CLS_DELIM; end
                nonempty[1] = 1; return CLS_TARGET;
            end
            if (vpos < 7) vpos = (c == pre[vpos]) ? vpos + 1 : 4'd15;
            else if (vpos == 7) begin
                if (c == 8'd49) begin v11 = 1; vpos = 8; end
                else if (c == 8'd48) begin v11 = 0; vpos = 8; end
                else vpos = 15;
            end else vpos = 15;
            return CLS_VER;
        end
        nonempty[0] = 1;
        if (!colon) begin
            if (c == 8'd58) begin
                colon = 1;
                for (int i = 0; i < 2; i++) begin
                    nlen = (i == 0) ? 14 : 10;
                    if (nmat[i] == nlen && !found[i]) found[i] = 1;
                    else nmat[i] = 31;
                end
                return CLS_DELIM;
            end
            if (!is_space(c)) nonempty[1] = 1;
            for (int i = 0; i < 2; i++) begin
                nlen = (i == 0) ? 14 : 10;
                if (nmat[i] != 31) begin
                    if (is_space(c)) begin
                        if (nmat[i] != 0 && nmat[i] != nlen) nmat[i] = 31;
                    end else if (nmat[i] < nlen && fold(c) == name_char(i, nmat[i]))
                        nmat[i] = nmat[i] + 1;
                    else nmat[i] = 31;
                end
            end
            return CLS_NAME;
        end
        // content-length value: sign then digits, saturating
        if (nmat[0] == 14) begin
            bit dig;
            bit add;
            dig = c >= 8'd48 && c <= 8'd57;
            add = 0;
            case (lsign)
                2'd0: begin
                    if (is_space(c)) ;
                    else if (c == 8'd43) lsign = 1;
                    else if (c == 8'd45) lsign = 2;
                    else if (!dig) lsign = 3;
                    else begin lsign = 1; add = 1; end
                end
                2'd1: if (!dig) lsign = 3; else add = 1;
                2'd2: if (!dig) lsign = 3;
                default: ;
            endcase
            if (add) begin
                len_acc = len_acc * 64'd10 + 64'(c - 8'd48);
                if (len_acc > 64'hFFFF_FFFF) len_acc = 64'hFFFF_FFFF;
            end
        end
        // connection words, case-blind
        if (nmat[1] == 10) begin
            for (int i = 0; i < 2; i++) begin
                wl = (i == 0) ? 5 : 10;
                m = wmat[i];
                if (m < wl) begin
                    if (fold(c) == word_char(i, m)) m++;
                    else m = (fold(c) == word_char(i, 0)) ? 1 : 0;
                    wmat[i] = m;
                end
            end
        end
        return CLS_VALUE;
    endfunction

    // lf that ends a line; returns header block end
    function automatic logic end_of_line();
        if (ph == PH_REQ) begin
            ph = (lfield == 2 && nonempty == 3 && vpos == 8) ? PH_HDR : PH_ERR;
            line_clear();
            return 0;
        end
        if (!colon && !nonempty[0]) begin
            if (found[1] && wmat[0] >= 5) verdict = CONN_CLOSE;
            else if (found[1] && wmat[1] >= 10) verdict = CONN_KEEP;
            else verdict = v11 ? CONN_KEEP : CONN_CLOSE;
            remain = len_acc[31:0];
            ph = (remain == 0) ? PH_DONE : PH_BODY;
            line_clear();
            return 1;
        end
        if (!colon || !nonempty[1]) ph = PH_ERR;
        line_clear();
        return 0;
    endfunction

    function automatic t_result parse_byte(logic restart, logic [7:0] c);
        t_result r;
        bit tail;
        r = '0;
        r.byte_out = c;
        r.byte_class = CLS_IGN;
        if (restart) begin
            parser_clear();
            return r;
        end
        if (ph == PH_REQ || ph == PH_HDR) begin
            if (cr_held && c != 8'd10) begin
                void'(take_content(8'd13));
                r.prev_cr_was_data = 1;
                cr_held = 0;
            end
            if (cr_held) begin
                cr_held = 0;
                r.byte_class = CLS_DELIM;
                r.headers_done = end_of_line();
            end else if (c == 8'd13) begin
                cr_held = 1;
                r.byte_class = CLS_DELIM;
            end else r.byte_class = take_content(c);
        end else if (ph == PH_BODY) begin
            r.byte_class = CLS_BODY;
            if (remain > 0) remain--;
            if (remain == 0) ph = PH_DONE;
        end
        r.parse_status = (ph == PH_ERR) ? ST_ERR : (ph == PH_DONE) ? ST_DONE : ST_MORE;
        tail = ph == PH_BODY || ph == PH_DONE;
        r.keep_alive = tail && verdict == CONN_KEEP;
        r.body_length = tail ? len_acc[31:0] : 32'd0;
        return r;
    endfunction

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            parser_clear();
            parsed_q.delete();
            fails = 0;
            for (int i = 0; i < 3; i++) o_status_seen[i] = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) parsed_q.push_back(parse_byte(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = '0;
                got.byte_out = i_m_tdata[7:0];
                got.prev_cr_was_data = i_m_tdata[8];
                got.parse_status = i_m_tdata[10:9];
                got.headers_done = i_m_tdata[11];
                got.keep_alive = i_m_tdata[12];
                got.body_length = i_m_tdata[44:13];
                got.byte_class = i_m_tuser;
                if (parsed_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected output transfer %h", $time, got);
                end else begin
                    want = parsed_q.pop_front();
                    if (want.parse_status < 3) o_status_seen[want.parse_status]++;
                    if (got.byte_out !== want.byte_out || got.byte_class !== want.byte_class
                        || got.prev_cr_was_data !== want.prev_cr_was_data
                        || got.parse_status !== want.parse_status
                        || got.headers_done !== want.headers_done
                        || got.keep_alive !== want.keep_alive
                        || got.body_length !== want.body_length
                        || i_m_tdata[47:45] !== 3'b000) begin
                        fails++;
                        $display("%0t: mismatch expected byte %h cls %0d crd %b st %0d hd %b ka %b len %0d",
                            $time, want.byte_out, want.byte_class, want.prev_cr_was_data,
                            want.parse_status, want.headers_done, want.keep_alive,
                            want.body_length);
                        $display("%0t:          actual   byte %h cls %0d crd %b st %0d hd %b ka %b len %0d",
                            $time, got.byte_out, got.byte_class, got.prev_cr_was_data,
                            got.parse_status, got.headers_done, got.keep_alive,
                            got.body_length);
                    end
                end
            end
        end
    end

endmodule

### dv/http_request_stream_parser_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// http_request_stream_parser_core_test
// Feeds directed and random HTTP requests, mostly well formed with random
// headers, lengths and bodies, plus broken lines and raw noise, with random
// gaps and back-pressure; the checker compares every output transfer.
// ----------------------------------------------------------------------------
module http_request_stream_parser_core_test;
    import hrsp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          status_seen [3];
    int          idle_cycles;
    int          sent;
    int          requests;
    bit          stim_done;

    localparam int WATCHDOG = 2000;

    http_request_stream_parser_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    http_request_stream_parser_core_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_s_tuser(s_tuser), .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_status_seen(status_seen)
    );

    // clock
    always begin
        clk = 1'b1; #10;
        clk = 1'b0; #10;
    end

    // receiver stalls, a fresh draw for each output transfer
    initial begin
        int wait_n;
        m_tready = 1'b0;
        @(negedge clk);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            @(negedge clk);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (!stim_done || pending > 0) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired at %0t", $time);
                $display("http_request_stream_parser_core verification failed");
                $finish;
            end
        end
    end

    // one input transfer, with a random gap first
    task automatic send_byte(logic restart, logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(1'b0, s[i]);
    endtask

    // random casing of a header name
    function automatic string mix_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(0, 1)) r[i] = r[i] - 8'd32;
        return r;
    endfunction

    function automatic string rand_token(int n);
        string r;
        r = "";
        for (int i = 0; i < n; i++) r = {r, string'(8'($urandom_range(33, 126)))};
        return r;
    endfunction

    // one random request, sometimes broken
    task automatic send_request();
        string   s;
        string   num;
        int      body_n;
        int      sel;
        body_n = 0;
        send_byte(1'b1, 8'($urandom_range(0, 255)));
        requests++;
        sel = $urandom_range(0, 9);
        s = {rand_token($urandom_range(1, 3)), " /", rand_token($urandom_range(0, 2)), " "};
        if (sel == 0) s = {s, "HTTP/2.0"};
        else if (sel == 1) s = {s, " HTTP/1.1"};
        else if (sel == 2) s = {"GET  HTTP/1.1"};
        else s = {s, $urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0"};
        send_text({s, "\r\n"});
        repeat ($urandom_range(0, 3)) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: begin
                    body_n = $urandom_range(0, 6);
                    num.itoa(body_n);
                    if ($urandom_range(0, 7) == 0) num = "-3";
                    if ($urandom_range(0, 9) == 0) num = "99999999999";
                    s = {" ", mix_case("content-length"), " : ", num, "\r\n"};
                end
                3, 4: s = {mix_case("connection"), ": ",
                           $urandom_range(0, 1) ? "Keep-Alive" : "xclose,y", "\r\n"};
                5: s = {rand_token(4), ":", rand_token(3), "\r\n"};
                6: s = {"nocolon\r\n"};
                7: s = {" :v\r\n"};
                8: s = {"A:b\rc\n\r\n"};
                default: s = {"X:", string'(8'($urandom_range(0, 255))), "\r\n"};
            endcase
            send_text(s);
        end
        send_text("\r\n");
        repeat ($urandom_range(0, 7)) send_byte(1'b0, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        sent = 0;
        requests = 0;
        stim_done = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: a full request with keep-alive and body, a saturating
        // length, a bad version, and extreme bytes
        send_text("GET / HTTP/1.0\r\nconnection: keep-alive\r\nContent-Length:+2\r\n\r\nabxx");
        send_byte(1'b1, 8'hFF);
        send_text("P x HTTP/1.1\r\nContent-Length: 5000000000\r\nConnection: close\r\n\r\n");
        send_byte(1'b1, 8'h00);
        send_text("GET / HTTP/1.2\r\n\r\n\xff");

        // random part
        while (sent < 450) begin
            if ($urandom_range(0, 9) == 0)
                repeat (8) send_byte($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
            else send_request();
        end
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        stim_done = 1;

        while (pending > 0) @(posedge clk);
        repeat (5) @(posedge clk);
        $display("sent %0d bytes in %0d random requests; results: %0d more, %0d complete, %0d error",
            sent, requests, status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0) $display("http_request_stream_parser_core verification clean");
        else $display("http_request_stream_parser_core verification failed");
        $finish;
    end

endmodule
